[design/mrs_pkg.sv]
// shared types, constants and scaling tables for the reading scaler
package mrs_pkg;

  // field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned SampleW = 8;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned RangeW  = 2;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NumDigits = 5;

  // divider sizing: numerator up to 255*50000, divisor up to 255*100
  localparam int unsigned NumerW  = 24;
  localparam int unsigned DenomW  = 15;
  localparam int unsigned RemW    = 16;
  localparam int unsigned StepCntW = $clog2(NumerW + 1);

  // digit unit: x/10 == (x*52429)>>19 for every 16-bit x
  localparam int unsigned RecipTen   = 52429;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned ProdW      = 33;
  localparam int unsigned DigCntW    = $clog2(NumDigits);

  localparam logic [ValueW-1:0]  ValueMax  = 16'hFFFF;
  localparam logic [SampleW-1:0] SampleMax = 8'd255;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_SAMPLE = 2'd0,
    OP_RETRY  = 2'd1,
    OP_MODE   = 2'd2,
    OP_RANGE  = 2'd3
  } op_e;

  // mode codes
  localparam logic [ModeW-1:0] MODE_VOLT = 2'd0;
  localparam logic [ModeW-1:0] MODE_AMP  = 2'd1;
  localparam logic [ModeW-1:0] MODE_OHM  = 2'd2;

  localparam logic [RangeW-1:0] RANGE_LOW  = 2'd0;
  localparam logic [RangeW-1:0] RANGE_MID  = 2'd1;
  localparam logic [RangeW-1:0] RANGE_HIGH = 2'd2;

  typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;

  // 500*k for ranges 0..2; also the overrange limit and the amps scale
  function automatic logic [ValueW-1:0] range_limit(logic [RangeW-1:0] r);
    logic [ValueW-1:0] v;
    case (r)
      RANGE_LOW: v = 16'd500;
      RANGE_MID: v = 16'd5000;
      default:   v = 16'd50000;
    endcase
    return v;
  endfunction

  // 255*k amps divisor of the current range, k = 100, 10, 1
  function automatic logic [DenomW-1:0] amp_divisor(logic [RangeW-1:0] r);
    logic [DenomW-1:0] v;
    case (r)
      RANGE_LOW: v = 15'd25500;
      RANGE_MID: v = 15'd2550;
      default:   v = 15'd255;
    endcase
    return v;
  endfunction

endpackage

[design/mrs_div.sv]
// restoring divider, one quotient bit per cycle
module mrs_div import mrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NumerW-1:0] numer_i,
  input  logic [DenomW-1:0] denom_i,
  output logic              done_o,
  output logic [NumerW-1:0] quot_o
);

  logic                busy_q;
  logic                done_q;
  logic [StepCntW-1:0] cnt_q;
  logic [NumerW-1:0]   quot_q, quot_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [DenomW-1:0]   denom_q;
  logic [RemW:0]       trial;
  logic [RemW:0]       diff;
  logic                fits;

  // one shift-subtract step
  always_comb begin
    trial  = {rem_q, quot_q[NumerW-1]};
    diff   = trial - (RemW+1)'(denom_q);
    fits   = trial >= (RemW+1)'(denom_q);
    rem_d  = fits ? diff[RemW-1:0] : trial[RemW-1:0];
    quot_d = {quot_q[NumerW-2:0], fits};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= StepCntW'(NumerW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == StepCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q  <= numer_i;
      rem_q   <= '0;
      denom_q <= denom_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[design/mrs_bcd.sv]
// decimal digit split, one digit per cycle from the ones upward
module mrs_bcd import mrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ValueW-1:0] value_i,
  output logic              done_o,
  output digits_t           digits_o
);

  logic               busy_q;
  logic               done_q;
  logic [DigCntW-1:0] idx_q;
  logic [ValueW-1:0]  rest_q;
  digits_t            digits_q;
  logic [ProdW-1:0]   prod;
  logic [ValueW-1:0]  quot;
  logic [ValueW-1:0]  times_ten;
  logic [ValueW-1:0]  rem;

  // divide by ten through the reciprocal
  always_comb begin
    prod      = ProdW'(rest_q) * ProdW'(RecipTen);
    quot      = ValueW'(prod >> RecipShift);
    times_ten = ValueW'({quot, 3'b000}) + ValueW'({quot, 1'b0});
    rem       = rest_q - times_ten;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q == DigCntW'(NumDigits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rest_q <= value_i;
    end else if (busy_q) begin
      rest_q          <= quot;
      digits_q[idx_q] <= rem[DigitW-1:0];
    end
  end

  assign done_o   = done_q;
  assign digits_o = digits_q;

endmodule

[design/multimeter_reading_scaler.sv]
// top level: mode/range state, scaling sequencer and result register
// path: a measurement runs the multiply step, 24 divider steps, 5 digit steps and the
// output register; full-scale resistance skips the divider, other ops run only the digit steps
// flow: one item at a time; the next input beat is taken once the result has gone to
// the output register, later while a waiting output beat is stalled
// reset: asynchronous active low; mode, range, error hold, alarm cleared
module multimeter_reading_scaler import mrs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OpW-1:0]     operation_i,
  input  logic [SampleW-1:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               taken_o,
  output logic [ModeW-1:0]   mode_o,
  output logic [RangeW-1:0]  range_o,
  output logic [ValueW-1:0]  value_o,
  output logic [DigitW-1:0]  digit_ten_thousands_o,
  output logic [DigitW-1:0]  digit_thousands_o,
  output logic [DigitW-1:0]  digit_hundreds_o,
  output logic [DigitW-1:0]  digit_tens_o,
  output logic [DigitW-1:0]  digit_ones_o,
  output logic               overrange_o,
  output logic               alarm_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIVGO = 3'd2;
  localparam logic [2:0] S_DIVW  = 3'd3;
  localparam logic [2:0] S_CONV  = 3'd4;
  localparam logic [2:0] S_CONVW = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [ModeW-1:0]   mode_q;
  logic [RangeW-1:0]  range_q;
  logic               hold_q;
  logic               alarm_q;
  logic               measure_q;
  logic               retry_q;
  logic               over_q;
  logic [SampleW-1:0] sample_q;
  logic [ValueW-1:0]  value_q;
  logic [NumerW-1:0]  numer_q;
  logic [DenomW-1:0]  denom_q;

  logic               out_valid_q;
  logic               taken_q_o, over_q_o, alarm_q_o;
  logic [ModeW-1:0]   mode_q_o;
  logic [RangeW-1:0]  range_q_o;
  logic [ValueW-1:0]  value_q_o;
  digits_t            digits_q_o;

  logic               in_beat;
  logic               out_free;
  logic               sample_meas;
  logic               retry_meas;
  logic [RangeW-1:0]  eff_range;
  logic [ValueW-1:0]  limit;
  logic [NumerW-1:0]  product;
  logic [DenomW-1:0]  denom;
  logic               div_start, div_done;
  logic [NumerW-1:0]  quot;
  logic               quot_over;
  logic               bcd_start, bcd_done;
  digits_t            digits;

  assign in_beat     = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign sample_meas = (op_e'(operation_i) == OP_SAMPLE) && !hold_q;
  assign retry_meas  = (op_e'(operation_i) == OP_RETRY) && alarm_q;

  // scale factors for the current range; range 3 acts as range 2
  assign eff_range = (range_q == 2'd3) ? RANGE_HIGH : range_q;
  assign limit     = range_limit(eff_range);

  // numerator product and divisor selection
  always_comb begin
    if (mode_q == MODE_AMP) begin
      product = NumerW'(sample_q) * NumerW'(range_limit(RANGE_HIGH));
      denom   = amp_divisor(eff_range);
    end else if (mode_q == MODE_OHM) begin
      product = NumerW'(sample_q) * NumerW'(limit);
      denom   = DenomW'(SampleMax - sample_q);
    end else begin
      product = NumerW'(sample_q) * NumerW'(limit);
      denom   = DenomW'(SampleMax);
    end
  end

  assign quot_over = quot >= NumerW'(limit);
  assign div_start = (state_q == S_DIVGO);
  assign bcd_start = (state_q == S_CONV);

  mrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (numer_q),
    .denom_i (denom_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  mrs_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bcd_start),
    .value_i  (value_q),
    .done_o   (bcd_done),
    .digits_o (digits)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          state_d = (sample_meas || retry_meas) ? S_MUL : S_CONV;
        end
      end
      S_MUL: begin
        if (mode_q == MODE_OHM && sample_q == SampleMax) begin
          state_d = S_CONV;
        end else begin
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: state_d = S_DIVW;
      S_DIVW:  if (div_done) state_d = S_CONV;
      S_CONV:  state_d = S_CONVW;
      S_CONVW: if (bcd_done) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_VOLT;
      range_q     <= RANGE_LOW;
      hold_q      <= 1'b0;
      alarm_q     <= 1'b0;
      measure_q   <= 1'b0;
      retry_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // an output beat empties the register unless a new reading takes its place
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            measure_q <= sample_meas || retry_meas;
            retry_q   <= retry_meas;
            // mode and range steps
            if (op_e'(operation_i) == OP_MODE) begin
              mode_q  <= (mode_q >= MODE_OHM) ? MODE_VOLT : mode_q + 1'b1;
              range_q <= RANGE_LOW;
              hold_q  <= 1'b0;
              alarm_q <= 1'b0;
            end else if (op_e'(operation_i) == OP_RANGE) begin
              range_q <= (range_q >= RANGE_HIGH) ? RANGE_LOW : range_q + 1'b1;
              hold_q  <= 1'b0;
              alarm_q <= 1'b0;
            end
          end
        end
        S_MUL: begin
          // full-scale resistance is over range without a division
          if (mode_q == MODE_OHM && sample_q == SampleMax) begin
            hold_q  <= 1'b1;
            alarm_q <= !retry_q;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            hold_q <= quot_over;
            if (retry_q) begin
              alarm_q <= 1'b0;
            end else if (quot_over) begin
              alarm_q <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          sample_q <= sample_i;
          value_q  <= '0;
          over_q   <= 1'b0;
        end
      end
      S_MUL: begin
        numer_q <= product;
        denom_q <= denom;
        if (mode_q == MODE_OHM && sample_q == SampleMax) begin
          value_q <= ValueMax;
          over_q  <= 1'b1;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          over_q  <= quot_over;
          value_q <= (quot > NumerW'(ValueMax)) ? ValueMax : quot[ValueW-1:0];
        end
      end
      S_OUT: begin
        if (out_free) begin
          taken_q_o  <= measure_q;
          mode_q_o   <= mode_q;
          range_q_o  <= range_q;
          value_q_o  <= value_q;
          digits_q_o <= digits;
          over_q_o   <= over_q;
          alarm_q_o  <= alarm_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o            = (state_q != S_IDLE);
  assign out_valid_o           = out_valid_q;
  assign taken_o               = taken_q_o;
  assign mode_o                = mode_q_o;
  assign range_o               = range_q_o;
  assign value_o               = value_q_o;
  assign digit_ones_o          = digits_q_o[0];
  assign digit_tens_o          = digits_q_o[1];
  assign digit_hundreds_o      = digits_q_o[2];
  assign digit_thousands_o     = digits_q_o[3];
  assign digit_ten_thousands_o = digits_q_o[4];
  assign overrange_o           = over_q_o;
  assign alarm_o               = alarm_q_o;

endmodule
